// ----- rtl/core/rotate_source_address_unit_assert.svh -----
// Assertion macros shared by the rotate source address checker.
// Depends on nothing; included by files that assert.
`ifndef ROTATE_SOURCE_ADDRESS_UNIT_ASSERT_SVH
`define ROTATE_SOURCE_ADDRESS_UNIT_ASSERT_SVH

// same-cycle implication
`define RSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/rsa_pkg.sv -----
// Shared constants for the rotate source address unit.
// No dependencies.
`default_nettype none

package rsa_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_COS_ANGLE     = 3'd2,
    CFG_SIN_ANGLE     = 3'd3,
    CFG_SOURCE_WIDTH  = 3'd4,
    CFG_SOURCE_HEIGHT = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- rtl/core/rsa_cfg_regs.sv -----
// Configuration register file of the rotate source address unit.
// Depends on rsa_pkg.
`default_nettype none

module rsa_cfg_regs
  import rsa_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 14,
  parameter int unsigned CFG_W      = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [CFG_W-1:0]             cfg_wdata_i,
  output logic [COORD_BITS-1:0]        center_x_o,
  output logic [COORD_BITS-1:0]        center_y_o,
  output logic signed [FRAC_BITS+1:0]  cos_angle_o,
  output logic signed [FRAC_BITS+1:0]  sin_angle_o,
  output logic [COORD_BITS:0]          source_width_o,
  output logic [COORD_BITS:0]          source_height_o
);

  localparam int unsigned ANGLE_W = FRAC_BITS + 2;
  localparam int unsigned SIZE_W  = COORD_BITS + 1;

  logic [COORD_BITS-1:0] center_x_q, center_y_q;
  logic [ANGLE_W-1:0]    cos_q, sin_q;
  logic [SIZE_W-1:0]     width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      cos_q      <= ANGLE_W'(1) << FRAC_BITS;
      sin_q      <= '0;
      width_q    <= SIZE_W'(1) << COORD_BITS;
      height_q   <= SIZE_W'(1) << COORD_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_X:      center_x_q <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_CENTER_Y:      center_y_q <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_COS_ANGLE:     cos_q      <= cfg_wdata_i[ANGLE_W-1:0];
        CFG_SIN_ANGLE:     sin_q      <= cfg_wdata_i[ANGLE_W-1:0];
        CFG_SOURCE_WIDTH:  width_q    <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: height_q   <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign center_x_o      = center_x_q;
  assign center_y_o      = center_y_q;
  assign cos_angle_o     = $signed(cos_q);
  assign sin_angle_o     = $signed(sin_q);
  assign source_width_o  = width_q;
  assign source_height_o = height_q;

endmodule

`default_nettype wire

// ----- rtl/core/rsa_axis_map.sv -----
// One axis of the inverse rotation: origin + a*ca +/- b*cb, floored and
// range checked against the source size. No dependencies.
`default_nettype none

module rsa_axis_map #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 14,
  parameter bit          SUB_B      = 1'b0
) (
  input  wire  [COORD_BITS-1:0]        origin_i,
  input  wire  signed [COORD_BITS:0]   d_a_i,
  input  wire  signed [FRAC_BITS+1:0]  coef_a_i,
  input  wire  signed [COORD_BITS:0]   d_b_i,
  input  wire  signed [FRAC_BITS+1:0]  coef_b_i,
  input  wire  [COORD_BITS:0]          size_i,
  output logic [COORD_BITS-1:0]        idx_o,
  output logic                         inside_o
);

  localparam int unsigned PROD_W = COORD_BITS + FRAC_BITS + 3;
  localparam int unsigned SUM_W  = COORD_BITS + FRAC_BITS + 5;
  localparam int unsigned INT_W  = SUM_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic signed [SUM_W-1:0]  base, sum;
  logic [INT_W-1:0]         int_part;
  logic                     over;

  always_comb begin
    prod_a   = d_a_i * coef_a_i;
    prod_b   = d_b_i * coef_b_i;
    base     = $signed({{(SUM_W-COORD_BITS-FRAC_BITS){1'b0}}, origin_i, {FRAC_BITS{1'b0}}});
    if (SUB_B) begin
      sum = base + SUM_W'(prod_a) - SUM_W'(prod_b);
    end else begin
      sum = base + SUM_W'(prod_a) + SUM_W'(prod_b);
    end
    int_part = sum[SUM_W-1:FRAC_BITS];
    over     = |int_part[INT_W-1:COORD_BITS];
    inside_o = !sum[SUM_W-1] && !over && (int_part < INT_W'(size_i));
    idx_o    = int_part[COORD_BITS-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/rotate_source_address_unit.sv -----
// Rotate source address unit: top level, input and result registers.
// Depends on rsa_pkg, rsa_cfg_regs and rsa_axis_map.
//
// Maps each destination pixel to the nearest-lower source pixel of an
// inverse rotation about the configured center with fixed-point cos/sin
// (FRAC_BITS fraction bits). One item is taken per clock while the output
// is not stalled; a result is offered once its item has passed the input
// register and then the result register. The path between them is two
// multiplies and an add per axis plus the range compare. A stall on the
// output holds both stages; the input stays ready while the input register
// is empty or can drain into a free result register. Pixels off the source
// image come out with outside set in tuser and zero coordinates. Write the
// configuration only while no item is in flight.
`default_nettype none

module rotate_source_address_unit
  import rsa_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [((FRAC_BITS+2 > COORD_BITS+1) ? FRAC_BITS+2 : COORD_BITS+1)-1:0] cfg_wdata_i,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  // dest_x, dest_y
  input  wire  [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  // source_x, source_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // outside
  output logic                    m_axis_tuser
);

  localparam int unsigned CFG_W  = (FRAC_BITS + 2 > COORD_BITS + 1) ? FRAC_BITS + 2
                                                                    : COORD_BITS + 1;
  localparam int unsigned TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  logic [COORD_BITS-1:0]       center_x, center_y;
  logic signed [FRAC_BITS+1:0] cos_angle, sin_angle;
  logic [COORD_BITS:0]         source_width, source_height;

  rsa_cfg_regs #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .CFG_W     (CFG_W)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .center_x_o     (center_x),
    .center_y_o     (center_y),
    .cos_angle_o    (cos_angle),
    .sin_angle_o    (sin_angle),
    .source_width_o (source_width),
    .source_height_o(source_height)
  );

  // handshake
  logic in_valid_q, out_valid_q;
  logic adv_out, adv_in;

  assign adv_out       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv_out;
  assign adv_in        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv_out) out_valid_q <= in_valid_q;
    end
  end

  // input register
  logic [COORD_BITS-1:0] dest_x_q, dest_y_q;

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      dest_x_q <= s_axis_tdata[COORD_BITS-1:0];
      dest_y_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  // mapping
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      idx_x, idx_y;
  logic                       in_x, in_y;

  assign dx = $signed({1'b0, dest_x_q}) - $signed({1'b0, center_x});
  assign dy = $signed({1'b0, dest_y_q}) - $signed({1'b0, center_y});

  rsa_axis_map #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .SUB_B     (1'b0)
  ) u_map_x (
    .origin_i(center_x),
    .d_a_i   (dx),
    .coef_a_i(cos_angle),
    .d_b_i   (dy),
    .coef_b_i(sin_angle),
    .size_i  (source_width),
    .idx_o   (idx_x),
    .inside_o(in_x)
  );

  rsa_axis_map #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .SUB_B     (1'b1)
  ) u_map_y (
    .origin_i(center_y),
    .d_a_i   (dy),
    .coef_a_i(cos_angle),
    .d_b_i   (dx),
    .coef_b_i(sin_angle),
    .size_i  (source_height),
    .idx_o   (idx_y),
    .inside_o(in_y)
  );

  // result register
  logic [COORD_BITS-1:0] source_x_q, source_y_q, source_x_d, source_y_d;
  logic                  outside_q, outside_d;

  always_comb begin
    outside_d  = !(in_x && in_y);
    source_x_d = outside_d ? '0 : idx_x;
    source_y_d = outside_d ? '0 : idx_y;
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && in_valid_q) begin
      source_x_q <= source_x_d;
      source_y_q <= source_y_d;
      outside_q  <= outside_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({source_y_q, source_x_q});
  assign m_axis_tuser  = outside_q;

endmodule

`default_nettype wire

// ----- rtl/core/rsa_checker.sv -----
// Port-level checks of the rotate source address unit, bound to the top.
// Depends on rotate_source_address_unit_assert.svh.
`default_nettype none
`include "rotate_source_address_unit_assert.svh"

module rsa_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 14
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input wire                  m_axis_tuser
);

  // a stalled result holds
  `RSA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // off-image results carry zero coordinates
  `RSA_ASSERT_IMP(a_outside_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata == '0)

  // an empty result register never blocks the input
  `RSA_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // after an accepted item has passed the input and result registers, the output is valid
  `RSA_ASSERT_IMP(a_latency, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                  ##2 m_axis_tvalid)

endmodule

bind rotate_source_address_unit rsa_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_rsa_checker (.*);

`default_nettype wire
